[rtl/msde_pkg.sv]
// msde_pkg: shared types and constants for the switch debouncer with edge latch
// holds the item and result words, the hold-off control struct and code names
// no dependencies
package msde_pkg;

  localparam int CHAN_MAX = 16;  // width of the per-channel bit vectors
  localparam int CHAN_W   = 4;   // channel number width
  localparam int CNT_W    = 9;   // hold-off counter width
  localparam int HOLD_W   = 8;   // holdoff_ms width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [HOLD_W-1:0]   HOLDOFF_RESET  = 8'd100;
  localparam logic [CHAN_MAX-1:0] IRQ_MASK_RESET = 16'hC302;

  // function codes
  localparam logic [1:0] FUNC_TICK      = 2'd0;
  localparam logic [1:0] FUNC_EVENT     = 2'd1;
  localparam logic [1:0] FUNC_CLEAR_ALL = 2'd2;
  localparam logic [1:0] FUNC_CLEAR_ONE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IRQ_MASK = 2'd1;

  typedef struct packed {
    logic [1:0]        func;
    logic [CHAN_W-1:0] channel;
    logic              pressed;
  } item_word_t;

  typedef struct packed {
    logic [CHAN_MAX-1:0] debounced_bits;
    logic [CHAN_MAX-1:0] edge_bits;
    logic                edge_hit;
    logic                change_accepted;
    logic                irq_valid;
    logic [CHAN_W-1:0]   irq_channel;
  } result_word_t;

  typedef struct packed {
    logic              tick;
    logic              load;
    logic [CHAN_W-1:0] chan;
  } hold_ctl_t;

endpackage

[rtl/msde_holdoff.sv]
// msde_holdoff: one lockout counter per channel
// counts down on tick, reloads to holdoff+1 on an accepted change
// depends on msde_pkg
module msde_holdoff
  import msde_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  hold_ctl_t           ctl,
  input  logic [HOLD_W-1:0]   holdoff_ms,
  output logic [CHAN_MAX-1:0] ready
);

  for (genvar i = 0; i < CHAN_MAX; i++) begin : g_chan
    if (i < CHANNELS) begin : g_used
      logic [CNT_W-1:0] cnt;

      always_ff @(posedge clk) begin
        if (rst) begin
          cnt <= '0;
        end else if (ctl.load && (ctl.chan == CHAN_W'(i))) begin
          cnt <= {1'b0, holdoff_ms} + CNT_W'(1);
        end else if (ctl.tick && (cnt != '0)) begin
          cnt <= cnt - CNT_W'(1);
        end
      end

      assign ready[i] = (cnt == '0);
    end else begin : g_unused
      assign ready[i] = 1'b0;
    end
  end

endmodule

[rtl/multi_switch_debouncer_edge_latch_core.sv]
// multi_switch_debouncer_edge_latch_core: lockout debouncer for up to 16 switches
// with a press-edge latch and per-channel interrupt enable
// depends on msde_pkg and msde_holdoff
//
// result path: an accepted word passes the input register, then the result register
// throughput: one word per cycle while results are taken; the state update between the two
// registers is combinational; the input register can take the next word while a result waits
// reset (rst, synchronous): debounced state, latches and counters clear, holdoff = 100,
// irq mask = 0xC302, both stages empty
module multi_switch_debouncer_edge_latch_core
  import msde_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // item channel
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_word_t            item,
  // result channel
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_word_t          result,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [HOLD_W-1:0]   holdoff_ms;
  logic [CHAN_MAX-1:0] irq_mask;

  // switch state; bits at and above CHANNELS never get set
  logic [CHAN_MAX-1:0] debounced;
  logic [CHAN_MAX-1:0] edge_latch;
  logic [CHAN_MAX-1:0] debounced_next;
  logic [CHAN_MAX-1:0] edge_latch_next;

  // input stage
  logic       s1_valid;
  item_word_t s1;

  logic         advance;
  result_word_t result_next;
  hold_ctl_t    hold_ctl;
  logic [CHAN_MAX-1:0] ready;

  logic                ch_ok;
  logic [CHAN_MAX-1:0] ch_bit;
  logic                cur_level;
  logic                accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff_ms <= HOLDOFF_RESET;
      irq_mask   <= IRQ_MASK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HOLDOFF:  holdoff_ms <= cfg_data[HOLD_W-1:0];
        REG_IRQ_MASK: irq_mask   <= cfg_data[CHAN_MAX-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow: stage 1 moves into the result register when that is free or draining
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1 <= item;
    end
  end

  // per-word decode
  assign ch_ok     = ({1'b0, s1.channel} < (CHAN_W + 1)'(CHANNELS));
  assign ch_bit    = CHAN_MAX'(1) << s1.channel;
  assign cur_level = debounced[s1.channel];
  // a change counts only outside lockout and when the level really differs
  assign accept    = (s1.func == FUNC_EVENT) && ch_ok && ready[s1.channel]
                     && (s1.pressed != cur_level);

  always_comb begin
    debounced_next  = debounced;
    edge_latch_next = edge_latch;

    result_next                 = '0;
    result_next.edge_bits       = edge_latch;
    result_next.change_accepted = accept;

    case (s1.func)
      FUNC_EVENT: begin
        if (accept) begin
          if (s1.pressed) begin
            debounced_next  = debounced | ch_bit;
            edge_latch_next = edge_latch | ch_bit;
            // interrupt only on presses of enabled channels
            if (irq_mask[s1.channel]) begin
              result_next.irq_valid   = 1'b1;
              result_next.irq_channel = s1.channel;
            end
          end else begin
            debounced_next  = debounced & ~ch_bit;
            edge_latch_next = edge_latch & ~ch_bit;
          end
        end
      end
      FUNC_CLEAR_ALL: begin
        edge_latch_next = '0;
      end
      FUNC_CLEAR_ONE: begin
        if (ch_ok) begin
          result_next.edge_hit = edge_latch[s1.channel];
          edge_latch_next      = edge_latch & ~ch_bit;
        end
      end
      default: ;  // tick: counters only
    endcase

    result_next.debounced_bits = debounced_next;
  end

  // counters move with the word that leaves stage 1
  assign hold_ctl.tick = advance && (s1.func == FUNC_TICK);
  assign hold_ctl.load = advance && accept;
  assign hold_ctl.chan = s1.channel;

  msde_holdoff #(
    .CHANNELS (CHANNELS)
  ) u_holdoff (
    .clk        (clk),
    .rst        (rst),
    .ctl        (hold_ctl),
    .holdoff_ms (holdoff_ms),
    .ready      (ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      debounced  <= '0;
      edge_latch <= '0;
    end else if (advance) begin
      debounced  <= debounced_next;
      edge_latch <= edge_latch_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // an interrupt always comes from an accepted change
  a_irq_needs_change: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.irq_valid || result.change_accepted))
    else $error("interrupt without accepted change");

  // a latched edge always belongs to a pressed switch
  a_latch_subset: assert property (@(posedge clk) disable iff (rst)
    (edge_latch & ~debounced) == '0)
    else $error("edge latch set on a released channel");

  // an accepted change leaves the channel in lockout
  a_lockout_after_change: assert property (@(posedge clk) disable iff (rst)
    hold_ctl.load |=> !ready[$past(s1.channel)])
    else $error("channel not locked after accepted change");

  // an accepted change puts the sampled level into the debounced state
  a_level_follows: assert property (@(posedge clk) disable iff (rst)
    hold_ctl.load |=> (debounced[$past(s1.channel)] == $past(s1.pressed)))
    else $error("debounced bit does not follow accepted change");

  // nothing is held in either stage right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule

[tb/sv/multi_switch_debouncer_edge_latch_core_tb.sv]
// multi_switch_debouncer_edge_latch_core_tb: self-checking bench for the lockout debouncer
// drives switch words and register writes, predicts every result word and checks it
// depends on msde_pkg and multi_switch_debouncer_edge_latch_core
module multi_switch_debouncer_edge_latch_core_tb;
  import msde_pkg::*;

  localparam int N_CH       = 16;    // channels built into the dut
  localparam int QUIET_MAX  = 1000;  // cycles with no handshake before giving up
  localparam int HOLD_LEN   = 80;    // long result hold-off, in cycles
  localparam int SHOW_MAX   = 20;    // mismatch lines printed before going quiet

  // clock, reset and every dut input start at a known value
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  item_word_t            item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_word_t          result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // switch words waiting to be offered, and result words still owed by the dut
  item_word_t   switch_words[$];
  result_word_t awaited_snapshots[$];

  // shadow copy of the debouncer: registers and state
  logic [HOLD_W-1:0]   holdoff_now;
  logic [CHAN_MAX-1:0] irq_mask_now;
  logic [CHAN_MAX-1:0] level_now;
  logic [CHAN_MAX-1:0] latch_now;
  logic [CNT_W-1:0]    lockout[N_CH];

  // stall settings per phase, percent of cycles spent idle
  int send_idle_pct = 15;
  int recv_idle_pct = 61;

  // long result hold-off: armed once the accepted word count reaches hold_at
  int words_in = 0;
  int hold_at = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  int quiet = 0;
  int err_count = 0;
  int func_seen[4] = '{0, 0, 0, 0};
  int taken_seen = 0;
  int irq_seen = 0;

  multi_switch_debouncer_edge_latch_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one switch word through the shadow debouncer; returns the word the dut owes
  function automatic result_word_t debounce_step(item_word_t w);
    result_word_t        r;
    logic [CHAN_MAX-1:0] sel;
    int                  i;
    r = '0;
    // latches as they stood before this word touched them
    r.edge_bits = latch_now;
    sel = CHAN_MAX'(1) << w.channel;
    case (w.func)
      FUNC_TICK: begin
        // every running lockout counts down, idle ones stay at zero
        for (i = 0; i < N_CH; i++)
          if (lockout[i] != '0) lockout[i] = lockout[i] - CNT_W'(1);
      end
      FUNC_EVENT: begin
        // only a real change on an unlocked channel counts
        if (int'(w.channel) < N_CH && lockout[w.channel] == '0 &&
            w.pressed != level_now[w.channel]) begin
          r.change_accepted = 1'b1;
          // hold-off of zero still locks for one tick
          lockout[w.channel] = {1'b0, holdoff_now} + CNT_W'(1);
          if (w.pressed) begin
            level_now = level_now | sel;
            latch_now = latch_now | sel;
            if (irq_mask_now[w.channel]) begin
              r.irq_valid = 1'b1;
              r.irq_channel = w.channel;
            end
          end else begin
            // a release drops the press latch too
            level_now = level_now & ~sel;
            latch_now = latch_now & ~sel;
          end
        end
      end
      FUNC_CLEAR_ALL: begin
        latch_now = '0;
      end
      FUNC_CLEAR_ONE: begin
        if (int'(w.channel) < N_CH) begin
          r.edge_hit = latch_now[w.channel];
          latch_now = latch_now & ~sel;
        end
      end
      default: ;
    endcase
    r.debounced_bits = level_now;
    return r;
  endfunction

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    if (err_count < SHOW_MAX)
      $display("mismatch at word %0d: %s got %0h want %0h", words_in, what, got, want);
    err_count++;
  endtask

  // sender: offers the next queued switch word, holds it until taken
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
    end else begin
      if (item_valid && item_ready) begin
        awaited_snapshots.push_back(debounce_step(item));
        func_seen[item.func]++;
        if (awaited_snapshots[$].change_accepted) taken_seen++;
        if (awaited_snapshots[$].irq_valid) irq_seen++;
        words_in <= words_in + 1;
      end
      // slot is free: either nothing offered or the last word went in
      if (!item_valid || item_ready) begin
        if (switch_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= switch_words.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each taken result word against the oldest one owed
  always @(posedge clk) begin : receiver
    result_word_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (awaited_snapshots.size() == 0) begin
          log_mismatch("result word with nothing owed", 32'(result.debounced_bits), '0);
        end else begin
          want = awaited_snapshots.pop_front();
          if (result.debounced_bits !== want.debounced_bits)
            log_mismatch("debounced_bits", 32'(result.debounced_bits),
                         32'(want.debounced_bits));
          if (result.edge_bits !== want.edge_bits)
            log_mismatch("edge_bits", 32'(result.edge_bits), 32'(want.edge_bits));
          if (result.edge_hit !== want.edge_hit)
            log_mismatch("edge_hit", 32'(result.edge_hit), 32'(want.edge_hit));
          if (result.change_accepted !== want.change_accepted)
            log_mismatch("change_accepted", 32'(result.change_accepted),
                         32'(want.change_accepted));
          if (result.irq_valid !== want.irq_valid)
            log_mismatch("irq_valid", 32'(result.irq_valid), 32'(want.irq_valid));
          if (result.irq_channel !== want.irq_channel)
            log_mismatch("irq_channel", 32'(result.irq_channel), 32'(want.irq_channel));
        end
      end
      // ready stays low through the long hold-off so the pipe backs up
      result_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long result hold-off, counted here while the sender keeps offering words
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && hold_at != 0 && words_in >= hold_at) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("timeout: no handshake for %0d cycles", QUIET_MAX);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // register write; the shadow copy follows at the accepting edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HOLDOFF:  holdoff_now = data[HOLD_W-1:0];
      REG_IRQ_MASK: irq_mask_now = data;
      default: ;
    endcase
  endtask

  task automatic add(input logic [1:0] f, input int ch, input bit p);
    item_word_t w;
    w.func = f;
    w.channel = CHAN_W'(ch);
    w.pressed = p;
    switch_words.push_back(w);
  endtask

  // wait until every word went in and every owed result came back
  task automatic settle();
    while (switch_words.size() != 0 || item_valid || awaited_snapshots.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // random words: tick_pct of them ticks, the rest mostly level events
  task automatic run_phase(input int n, input int tick_pct);
    item_word_t w;
    int         k;
    @(negedge clk);
    repeat (n) begin
      w.channel = CHAN_W'($urandom_range(N_CH - 1));
      w.pressed = 1'($urandom_range(1));
      k = $urandom_range(9);
      if ($urandom_range(99) < tick_pct) w.func = FUNC_TICK;
      else if (k < 7) w.func = FUNC_EVENT;
      else if (k < 9) w.func = FUNC_CLEAR_ONE;
      else w.func = FUNC_CLEAR_ALL;
      switch_words.push_back(w);
    end
    settle();
  endtask

  initial begin
    int i;
    // shadow state matches the reset values of the block
    holdoff_now = HOLDOFF_RESET;
    irq_mask_now = IRQ_MASK_RESET;
    level_now = '0;
    latch_now = '0;
    for (i = 0; i < N_CH; i++) lockout[i] = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, reset registers: hold-off 100, mask has channels 1, 8, 9, 14 and 15
    @(negedge clk);
    add(FUNC_CLEAR_ONE, 0, 1'b0);   // nothing latched yet
    add(FUNC_EVENT, 1, 1'b1);       // press on an enabled channel
    add(FUNC_EVENT, 0, 1'b1);       // press on a masked channel
    add(FUNC_EVENT, 0, 1'b0);       // release inside lockout, dropped
    add(FUNC_EVENT, 2, 1'b0);       // same as current level, no reload
    add(FUNC_EVENT, 2, 1'b1);       // so this one still counts
    add(FUNC_EVENT, 15, 1'b1);      // top channel with interrupt
    add(FUNC_TICK, 0, 1'b0);
    add(FUNC_CLEAR_ONE, 15, 1'b1);  // latch was set
    add(FUNC_CLEAR_ONE, 15, 1'b0);  // and is now clear
    add(FUNC_CLEAR_ALL, 15, 1'b1);
    add(FUNC_CLEAR_ONE, 1, 1'b0);
    settle();

    // directed, zero hold-off and every channel enabled
    write_reg(REG_HOLDOFF, 16'h0000);
    write_reg(REG_IRQ_MASK, 16'hFFFF);
    @(negedge clk);
    add(FUNC_EVENT, 3, 1'b1);       // locks for exactly one tick
    add(FUNC_EVENT, 3, 1'b0);       // still locked
    add(FUNC_TICK, 7, 1'b1);
    add(FUNC_EVENT, 3, 1'b0);       // unlocked, release clears the latch
    add(FUNC_EVENT, 3, 1'b1);
    add(FUNC_TICK, 0, 1'b0);
    add(FUNC_TICK, 0, 1'b0);        // idle counter stays at zero
    add(FUNC_EVENT, 3, 1'b1);
    add(FUNC_CLEAR_ONE, 3, 1'b1);
    add(FUNC_EVENT, 4, 1'b1);
    add(FUNC_CLEAR_ALL, 0, 1'b0);
    settle();

    // short lockout, random mask; upper data bits must not reach holdoff
    write_reg(REG_HOLDOFF, 16'h5C03);
    write_reg(REG_IRQ_MASK, CFG_DATA_W'($urandom_range(16'hFFFF)));
    run_phase(300, 30);

    // longest lockout, no interrupts; tick-heavy so counters run out
    write_reg(REG_HOLDOFF, 16'h00FF);
    write_reg(REG_IRQ_MASK, 16'h0000);
    send_idle_pct <= 61;
    recv_idle_pct <= 15;
    run_phase(400, 75);

    // hold-off 1, no idling, one long result hold-off mid-phase
    write_reg(REG_HOLDOFF, 16'h0001);
    write_reg(REG_IRQ_MASK, 16'h5A5A);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_at <= words_in + 50;
    run_phase(350, 35);

    // extra cycles in case the dut sends anything it does not owe
    repeat (10) @(posedge clk);
    $display("covered %0d words: %0d ticks, %0d level events (%0d taken, %0d interrupts)",
             words_in, func_seen[FUNC_TICK], func_seen[FUNC_EVENT], taken_seen, irq_seen);
    $display("latch reads: %0d clear-all, %0d clear-one; hold-off 100, 0, 3, 255 and 1",
             func_seen[FUNC_CLEAR_ALL], func_seen[FUNC_CLEAR_ONE]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
